[sv/qutv_pkg.sv]
// Package for the quoted UTF-8 text validator: widths, phase and rule codes,
// status codes and the UTF-8 lead byte helper functions.
// Depends on nothing; every other file of the block imports it.
package qutv_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int STAT_W = 2;

    // Largest decoded length the block will ever allow.
    localparam logic [LEN_W-1:0] MAX_TEXT_LIMIT = 11'd1024;
    localparam logic [LEN_W-1:0] CFG_RESET      = 11'd1024;

    // Scan phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_OPEN = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_CONT = 3'd3;
    localparam logic [2:0] PH_ACC  = 3'd4;
    localparam logic [2:0] PH_REJ  = 3'd5;

    // Restrictions on the first continuation byte.
    localparam logic [2:0] RULE_NONE = 3'd0;
    localparam logic [2:0] RULE_E0   = 3'd1;
    localparam logic [2:0] RULE_ED   = 3'd2;
    localparam logic [2:0] RULE_F0   = 3'd3;
    localparam logic [2:0] RULE_F4   = 3'd4;

    // Verdict codes on the result channel.
    localparam logic [STAT_W-1:0] ST_OPEN = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACC  = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJ  = 2'd2;

    // Byte codes of interest.
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;

    // Sequence length announced by a lead byte; zero for an illegal lead.
    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] c);
        logic [2:0] len;
        len = 3'd0;
        if (c < 8'h80)
            len = 3'd1;
        else if ((c & 8'he0) == 8'hc0 && c >= 8'hc2)
            len = 3'd2;
        else if ((c & 8'hf0) == 8'he0)
            len = 3'd3;
        else if ((c & 8'hf8) == 8'hf0 && c <= 8'hf4)
            len = 3'd4;
        return len;
    endfunction

    // Rule for the second byte that follows a given lead byte.
    function automatic logic [2:0] lead_rule(input logic [BYTE_W-1:0] c);
        logic [2:0] rule;
        rule = RULE_NONE;
        if (c == 8'he0)
            rule = RULE_E0;
        else if (c == 8'hed)
            rule = RULE_ED;
        else if (c == 8'hf0)
            rule = RULE_F0;
        else if (c == 8'hf4)
            rule = RULE_F4;
        return rule;
    endfunction

    // Check of the first continuation byte against its rule.
    function automatic logic second_ok(input logic [2:0] rule, input logic [BYTE_W-1:0] b);
        logic ok;
        unique case (rule)
            RULE_E0: ok = (b >= 8'ha0);
            RULE_ED: ok = (b < 8'ha0);
            RULE_F0: ok = (b >= 8'h90);
            RULE_F4: ok = (b < 8'h90);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

[sv/qutv_in_if.sv]
// Input channel of the validator: one raw byte and its framing flags per
// transaction. Depends on qutv_pkg for the byte width.
interface qutv_in_if import qutv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              start_req;
    logic              end_of_data;

    modport source (output valid, output text_byte, output start_req,
                    output end_of_data, input ready);
    modport sink   (input valid, input text_byte, input start_req,
                    input end_of_data, output ready);
endinterface

[sv/qutv_out_if.sv]
// Result channel of the validator: decoded byte, verdict and running length
// per transaction. Depends on qutv_pkg for the field widths.
interface qutv_out_if import qutv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              byte_valid;
    logic [BYTE_W-1:0] decoded_byte;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  text_length;

    modport source (output valid, output byte_valid, output decoded_byte,
                    output status, output text_length, input ready);
    modport sink   (input valid, input byte_valid, input decoded_byte,
                    input status, input text_length, output ready);
endinterface

[sv/quoted_utf8_text_validator.sv]
// The result of an accepted input transaction is held in the result register from the next cycle.
// Throughput: one byte per cycle while the consumer takes results; the scan state registers are
// updated in the same cycle the byte is accepted, and the result register frees itself as soon as
// the consumer takes its transaction.
// Reset (rst_n low, asynchronous): idle phase, no pending result, limit register 1024.
// Top level of the quoted UTF-8 text validator; depends on qutv_pkg and the two channel interfaces.
module quoted_utf8_text_validator
    import qutv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    qutv_in_if.sink            in_ch,
    qutv_out_if.source         out_ch,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata
);

    logic [LEN_W-1:0]  max_bytes_reg;
    logic [2:0]        phase_reg, phase_next;
    logic [1:0]        cont_left_reg, cont_left_next;
    logic [1:0]        cont_seen_reg, cont_seen_next;
    logic [2:0]        rule_reg, rule_next;
    logic [LEN_W-1:0]  byte_count_reg, byte_count_next;

    logic              out_valid_reg;
    logic              byte_valid_reg;
    logic [BYTE_W-1:0] decoded_byte_reg;
    logic [STAT_W-1:0] status_reg;
    logic [LEN_W-1:0]  text_length_reg;

    logic              in_fire;
    logic [LEN_W-1:0]  limit;
    logic [2:0]        seq_len;
    logic [LEN_W:0]    lead_total;
    logic [LEN_W:0]    esc_total;
    logic              active;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic [STAT_W-1:0] res_status;

    // The input is taken whenever the result register is empty or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Effective length limit, clamped to the hard maximum.
    assign limit = (max_bytes_reg > MAX_TEXT_LIMIT) ? MAX_TEXT_LIMIT : max_bytes_reg;

    // Lengths the scalar would reach after a lead byte or an escaped byte.
    assign seq_len    = lead_length(in_ch.text_byte);
    assign lead_total = {1'b0, byte_count_reg} + {{(LEN_W-2){1'b0}}, seq_len};
    assign esc_total  = {1'b0, byte_count_reg} + {{LEN_W{1'b0}}, 1'b1};

    // Next scan state and the result of the byte on the input channel.
    always_comb
    begin
        phase_next      = phase_reg;
        cont_left_next  = cont_left_reg;
        cont_seen_next  = cont_seen_reg;
        rule_next       = rule_reg;
        byte_count_next = byte_count_reg;
        active          = 1'b0;
        res_valid       = 1'b0;
        res_byte        = '0;

        if (in_ch.start_req)
        begin
            cont_left_next  = 2'd0;
            cont_seen_next  = 2'd0;
            rule_next       = RULE_NONE;
            byte_count_next = '0;
            phase_next      = (in_ch.text_byte == CH_QUOTE) ? PH_OPEN : PH_REJ;
            active          = 1'b1;
        end
        else if (phase_reg == PH_OPEN)
        begin
            active = 1'b1;
            priority if (in_ch.text_byte == CH_QUOTE)
            begin
                phase_next = PH_ACC;
            end
            else if (in_ch.text_byte < CH_SPACE || in_ch.text_byte == CH_DEL)
            begin
                phase_next = PH_REJ;
            end
            else if (in_ch.text_byte == CH_BSL)
            begin
                phase_next = PH_ESC;
            end
            else if (seq_len == 3'd0 || lead_total > {1'b0, limit})
            begin
                phase_next = PH_REJ;
            end
            else
            begin
                res_valid       = 1'b1;
                res_byte        = in_ch.text_byte;
                byte_count_next = esc_total[LEN_W-1:0];
                if (seq_len > 3'd1)
                begin
                    cont_left_next = 2'(seq_len - 3'd1);
                    cont_seen_next = 2'd0;
                    rule_next      = lead_rule(in_ch.text_byte);
                    phase_next     = PH_CONT;
                end
            end
        end
        else if (phase_reg == PH_ESC)
        begin
            active = 1'b1;
            if ((in_ch.text_byte == CH_QUOTE || in_ch.text_byte == CH_BSL)
                && esc_total <= {1'b0, limit})
            begin
                res_valid       = 1'b1;
                res_byte        = in_ch.text_byte;
                byte_count_next = esc_total[LEN_W-1:0];
                phase_next      = PH_OPEN;
            end
            else
            begin
                phase_next = PH_REJ;
            end
        end
        else if (phase_reg == PH_CONT)
        begin
            active = 1'b1;
            if (in_ch.text_byte[7:6] != 2'b10
                || (cont_seen_reg == 2'd0 && !second_ok(rule_reg, in_ch.text_byte)))
            begin
                phase_next = PH_REJ;
            end
            else
            begin
                res_valid       = 1'b1;
                res_byte        = in_ch.text_byte;
                byte_count_next = esc_total[LEN_W-1:0];
                cont_seen_next  = cont_seen_reg + 2'd1;
                cont_left_next  = cont_left_reg - 2'd1;
                rule_next       = RULE_NONE;
                if (cont_left_reg == 2'd1)
                    phase_next = PH_OPEN;
            end
        end

        // Data ending while the scalar is still open rejects it.
        if (active && in_ch.end_of_data
            && (phase_next == PH_OPEN || phase_next == PH_ESC || phase_next == PH_CONT))
            phase_next = PH_REJ;

        if (phase_next == PH_REJ)
        begin
            res_valid = 1'b0;
            res_byte  = '0;
        end

        if (phase_next == PH_ACC)
            res_status = ST_ACC;
        else if (phase_next == PH_REJ)
            res_status = ST_REJ;
        else
            res_status = ST_OPEN;
    end

    // Limit register, written by the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_bytes_reg <= CFG_RESET;
        else if (cfg_we)
            max_bytes_reg <= cfg_wdata;
    end

    // Scan state, advanced once per accepted input transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cont_left_reg  <= 2'd0;
            cont_seen_reg  <= 2'd0;
            rule_reg       <= RULE_NONE;
            byte_count_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            cont_left_reg  <= cont_left_next;
            cont_seen_reg  <= cont_seen_next;
            rule_reg       <= rule_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_valid_reg   <= res_valid;
            decoded_byte_reg <= res_byte;
            status_reg       <= res_status;
            text_length_reg  <= byte_count_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_valid   = byte_valid_reg;
    assign out_ch.decoded_byte = decoded_byte_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.text_length  = text_length_reg;

    // A decoded byte is only ever emitted while the scalar is still open.
    a_byte_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && byte_valid_reg) |-> (status_reg == ST_OPEN))
        else $error("decoded byte emitted with a final verdict");

    // Without a content byte the decoded byte reads as zero.
    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> (decoded_byte_reg == '0))
        else $error("decoded byte not cleared");

    // The length counter never passes the hard maximum.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_TEXT_LIMIT)
        else $error("byte count beyond limit");

    // Inside a multi-byte sequence at least one continuation byte is owed.
    a_cont_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CONT) |-> (cont_left_reg != 2'd0))
        else $error("continuation phase with nothing left");

    // Every emitted byte advances the length by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid) |=> (byte_count_reg == $past(byte_count_reg) + 1'b1))
        else $error("length did not follow emitted byte");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the quoted UTF-8 text validator: directed and random byte streams,
// an in-bench scan predictor and a field-by-field check of every result transaction.
// Depends on qutv_pkg, qutv_in_if, qutv_out_if and quoted_utf8_text_validator.
module testbench;
    import qutv_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              start_req;
        logic              end_of_data;
    } byte_item_t;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] decoded_byte;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  text_length;
    } scan_result_t;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 900;
    localparam int FEED_DEPTH   = 16;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    qutv_in_if  in_ch ();
    qutv_out_if out_ch ();

    quoted_utf8_text_validator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Bytes waiting to be sent; the head stays queued until its transaction completes.
    byte_item_t   byte_feed_q[$];
    // Results predicted for accepted bytes, oldest first.
    scan_result_t expected_scan_q[$];
    // Scratch buffer used while a scalar is being assembled.
    byte_item_t   scalar_buf[$];

    int mismatch_count;
    int cycle_count;
    int src_idle_pct;
    int snk_idle_pct;
    int random_item_count;

    // Predictor copy of the scan state and of the length register.
    logic [2:0]        scan_phase;
    logic [1:0]        seq_remaining;
    logic [BYTE_W-1:0] cont_lo;
    logic [BYTE_W-1:0] cont_hi;
    int                decoded_count;
    logic [LEN_W-1:0]  length_cap;

    // Number of bytes in the UTF-8 sequence that a lead byte opens, zero when illegal.
    function automatic int utf8_seq_len(input logic [BYTE_W-1:0] b);
        int n;
        casez (b)
            8'b0???????: n = 1;
            8'b110?????: n = (b >= 8'hc2) ? 2 : 0;
            8'b1110????: n = 3;
            8'b11110???: n = (b <= 8'hf4) ? 4 : 0;
            default:     n = 0;
        endcase
        return n;
    endfunction

    // Advance the predicted scan by one accepted byte and queue the result it causes.
    function automatic void advance_scan(input byte_item_t it);
        scan_result_t      res;
        logic              live;
        int                cap;
        int                n;
        logic [BYTE_W-1:0] b;
        b    = it.text_byte;
        res  = '0;
        live = 1'b0;
        cap  = (length_cap > MAX_TEXT_LIMIT) ? int'(MAX_TEXT_LIMIT) : int'(length_cap);
        if (it.start_req)
        begin
            seq_remaining = '0;
            cont_lo       = 8'h80;
            cont_hi       = 8'hbf;
            decoded_count = 0;
            scan_phase    = (b == CH_QUOTE) ? PH_OPEN : PH_REJ;
            live          = 1'b1;
        end
        else
        begin
            case (scan_phase)
                PH_OPEN:
                begin
                    live = 1'b1;
                    n    = utf8_seq_len(b);
                    if (b == CH_QUOTE)
                        scan_phase = PH_ACC;
                    else if (b < CH_SPACE || b == CH_DEL)
                        scan_phase = PH_REJ;
                    else if (b == CH_BSL)
                        scan_phase = PH_ESC;
                    else if (n == 0 || decoded_count + n > cap)
                        scan_phase = PH_REJ;
                    else
                    begin
                        res.byte_valid   = 1'b1;
                        res.decoded_byte = b;
                        decoded_count++;
                        if (n > 1)
                        begin
                            // Narrow the first continuation byte for the special leads.
                            seq_remaining = 2'(n - 1);
                            cont_lo = (b == 8'he0) ? 8'ha0 : (b == 8'hf0) ? 8'h90 : 8'h80;
                            cont_hi = (b == 8'hed) ? 8'h9f : (b == 8'hf4) ? 8'h8f : 8'hbf;
                            scan_phase = PH_CONT;
                        end
                    end
                end
                PH_ESC:
                begin
                    live = 1'b1;
                    if ((b == CH_QUOTE || b == CH_BSL) && decoded_count < cap)
                    begin
                        res.byte_valid   = 1'b1;
                        res.decoded_byte = b;
                        decoded_count++;
                        scan_phase = PH_OPEN;
                    end
                    else
                        scan_phase = PH_REJ;
                end
                PH_CONT:
                begin
                    live = 1'b1;
                    if (b < cont_lo || b > cont_hi)
                        scan_phase = PH_REJ;
                    else
                    begin
                        res.byte_valid   = 1'b1;
                        res.decoded_byte = b;
                        decoded_count++;
                        seq_remaining = seq_remaining - 2'd1;
                        cont_lo       = 8'h80;
                        cont_hi       = 8'hbf;
                        if (seq_remaining == 2'd0)
                            scan_phase = PH_OPEN;
                    end
                end
                default:
                    ;
            endcase
        end
        // Data that runs out with the scalar still open is a rejection.
        if (live && it.end_of_data &&
            (scan_phase == PH_OPEN || scan_phase == PH_ESC || scan_phase == PH_CONT))
            scan_phase = PH_REJ;
        if (scan_phase == PH_REJ)
        begin
            res.byte_valid   = 1'b0;
            res.decoded_byte = '0;
        end
        res.status = (scan_phase == PH_ACC) ? ST_ACC :
                     (scan_phase == PH_REJ) ? ST_REJ : ST_OPEN;
        res.text_length = LEN_W'(decoded_count);
        expected_scan_q.push_back(res);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte(input int lo, input int hi);
        return BYTE_W'($urandom_range(hi, lo));
    endfunction

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic s, input logic e);
        byte_feed_q.push_back(byte_item_t'{b, s, e});
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b);
        scalar_buf.push_back(byte_item_t'{b, 1'b0, 1'b0});
    endtask

    // Append one well-formed character: ASCII, an escape or a multi-byte sequence.
    task automatic add_char();
        logic [BYTE_W-1:0] lead;
        int                kind;
        kind = $urandom_range(9);
        if (kind <= 3)
        begin
            lead = rand_byte(8'h20, 8'h7e);
            if (lead == CH_QUOTE || lead == CH_BSL)
                add_byte(CH_BSL);
            add_byte(lead);
        end
        else if (kind == 4)
        begin
            add_byte(CH_BSL);
            add_byte($urandom_range(1) ? CH_QUOTE : CH_BSL);
        end
        else if (kind == 5)
        begin
            add_byte(rand_byte(8'hc2, 8'hdf));
            add_byte(rand_byte(8'h80, 8'hbf));
        end
        else if (kind <= 7)
        begin
            if (kind == 6)
                lead = $urandom_range(1) ? 8'he0 : 8'hed;
            else
                lead = rand_byte(8'he0, 8'hef);
            add_byte(lead);
            add_byte(rand_byte((lead == 8'he0) ? 8'ha0 : 8'h80,
                               (lead == 8'hed) ? 8'h9f : 8'hbf));
            add_byte(rand_byte(8'h80, 8'hbf));
        end
        else
        begin
            if (kind == 8)
                lead = $urandom_range(1) ? 8'hf0 : 8'hf4;
            else
                lead = rand_byte(8'hf0, 8'hf4);
            add_byte(lead);
            add_byte(rand_byte((lead == 8'hf0) ? 8'h90 : 8'h80,
                               (lead == 8'hf4) ? 8'h8f : 8'hbf));
            add_byte(rand_byte(8'h80, 8'hbf));
            add_byte(rand_byte(8'h80, 8'hbf));
        end
    endtask

    // Build one scalar with random content, optionally break it, and queue it.
    task automatic queue_scalar(input bit broken, input int max_chars);
        int pos;
        int mode;
        scalar_buf.delete();
        scalar_buf.push_back(byte_item_t'{CH_QUOTE, 1'b1, 1'b0});
        repeat ($urandom_range(max_chars)) add_char();
        add_byte(CH_QUOTE);
        scalar_buf[scalar_buf.size() - 1].end_of_data = 1'($urandom_range(1));
        if (broken)
        begin
            mode = $urandom_range(6);
            pos  = $urandom_range(scalar_buf.size() - 1, 1);
            case (mode)
                0: scalar_buf[pos].text_byte = rand_byte(0, 255);
                1:
                begin
                    // Control byte, DEL, stray continuation or C0/C1 lead, or out-of-range lead.
                    case ($urandom_range(3))
                        0:       scalar_buf[pos].text_byte = rand_byte(0, 8'h1f);
                        1:       scalar_buf[pos].text_byte = CH_DEL;
                        2:       scalar_buf[pos].text_byte = rand_byte(8'h80, 8'hc1);
                        default: scalar_buf[pos].text_byte = rand_byte(8'hf5, 8'hff);
                    endcase
                end
                2:
                begin
                    scalar_buf[pos].end_of_data = 1'b1;
                    while (scalar_buf.size() > pos + 1)
                        void'(scalar_buf.pop_back());
                end
                3:
                begin
                    void'(scalar_buf.pop_back());
                    scalar_buf[scalar_buf.size() - 1].end_of_data = 1'b1;
                end
                4: void'(scalar_buf.pop_back());
                5: scalar_buf[0].text_byte = rand_byte(0, 255);
                default:
                begin
                    scalar_buf[pos].start_req = 1'b1;
                    scalar_buf[pos].text_byte = $urandom_range(3) ? CH_QUOTE : rand_byte(0, 255);
                end
            endcase
        end
        random_item_count += scalar_buf.size();
        foreach (scalar_buf[i])
            byte_feed_q.push_back(scalar_buf[i]);
        // Occasional stray bytes between scalars.
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(3, 1))
                push_item(rand_byte(0, 255), 1'b0, 1'($urandom_range(1)));
    endtask

    // A scalar with a long run of plain ASCII, for the length limit at its largest.
    task automatic queue_long_scalar(input int content_len);
        push_item(CH_QUOTE, 1'b1, 1'b0);
        for (int i = 0; i < content_len; i++)
        begin
            while (byte_feed_q.size() > FEED_DEPTH)
                @(posedge clk);
            push_item(rand_byte(8'h5d, 8'h7e), 1'b0, 1'b0);
        end
        push_item(CH_QUOTE, 1'b0, 1'b1);
    endtask

    // Wait until every queued byte has been sent and every result has been checked.
    task automatic drain();
        while (byte_feed_q.size() != 0 || expected_scan_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_cap(input logic [LEN_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        length_cap = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run time guard.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[quoted_utf8_text_validator] ERROR");
            $finish;
        end
    end

    // Input driver: presents the head of the feed queue, honouring back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : driver
        byte_item_t taken;
        logic       hold;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.text_byte   <= '0;
            in_ch.start_req   <= 1'b0;
            in_ch.end_of_data <= 1'b0;
        end
        else
        begin
            hold = in_ch.valid && !in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                taken = byte_item_t'{in_ch.text_byte, in_ch.start_req, in_ch.end_of_data};
                advance_scan(taken);
                void'(byte_feed_q.pop_front());
            end
            if (!hold)
            begin
                if (byte_feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_ch.valid       <= 1'b1;
                    in_ch.text_byte   <= byte_feed_q[0].text_byte;
                    in_ch.start_req   <= byte_feed_q[0].start_req;
                    in_ch.end_of_data <= byte_feed_q[0].end_of_data;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each completed transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        scan_result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_scan_q.size() == 0)
                begin
                    $error("result transaction arrived with no prediction pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_scan_q.pop_front();
                    if (out_ch.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %0d, got %0d",
                               want.byte_valid, out_ch.byte_valid);
                        mismatch_count++;
                    end
                    if (out_ch.decoded_byte !== want.decoded_byte)
                    begin
                        $error("decoded_byte: expected %02h, got %02h",
                               want.decoded_byte, out_ch.decoded_byte);
                        mismatch_count++;
                    end
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        mismatch_count++;
                    end
                    if (out_ch.text_length !== want.text_length)
                    begin
                        $error("text_length: expected %0d, got %0d",
                               want.text_length, out_ch.text_length);
                        mismatch_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [LEN_W-1:0] cap_plan [10];
        int               phase_start;
        // Known values on every input from time zero.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.text_byte   = '0;
        in_ch.start_req   = 1'b0;
        in_ch.end_of_data = 1'b0;
        out_ch.ready      = 1'b0;
        scan_phase        = PH_IDLE;
        seq_remaining     = '0;
        cont_lo           = 8'h80;
        cont_hi           = 8'hbf;
        decoded_count     = 0;
        length_cap        = CFG_RESET;
        mismatch_count    = 0;
        cycle_count       = 0;
        random_item_count = 0;
        src_idle_pct      = 26;
        snk_idle_pct      = 77;
        cap_plan = '{11'd0, 11'd1, 11'd1024, 11'd3, 11'd2047,
                     11'd2, 11'd7, 11'd0, 11'd5, 11'd16};
        cap_plan[7] = LEN_W'($urandom_range(40));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset length limit.
        // Escaped quote and escaped backslash, then a normal close.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(CH_QUOTE, 1'b0, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(CH_QUOTE, 1'b0, 1'b0);
        // A byte after the close is ignored.
        push_item(8'h78, 1'b0, 1'b0);
        // Unsupported escape.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_BSL, 1'b0, 1'b0);
        push_item(8'h6e, 1'b0, 1'b0);
        // A new start abandons the open scalar; then an illegal lead byte.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(8'h41, 1'b0, 1'b0);
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        // Opening byte that is not a quote.
        push_item(8'h00, 1'b1, 1'b0);
        // Opening quote that is also the last byte.
        push_item(CH_QUOTE, 1'b1, 1'b1);
        // A quote inside a two-byte sequence does not close the scalar.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(8'hc2, 1'b0, 1'b0);
        push_item(CH_QUOTE, 1'b0, 1'b0);
        // DEL is rejected.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_DEL, 1'b0, 1'b0);
        // Data ends on a content byte.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(8'h61, 1'b0, 1'b1);
        // Empty scalar closed on the last byte.
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item(CH_QUOTE, 1'b0, 1'b1);

        // Random scalars under a series of length limits.
        foreach (cap_plan[k])
        begin
            write_cap(cap_plan[k]);
            if (cap_plan[k] == 11'd1024)
                queue_long_scalar(1024);
            if (cap_plan[k] == 11'd2047)
                queue_long_scalar(1025);
            phase_start = random_item_count;
            while (random_item_count - phase_start < RANDOM_ITEMS / 10)
            begin
                while (byte_feed_q.size() > FEED_DEPTH)
                    @(posedge clk);
                if (random_item_count < RANDOM_ITEMS / 3)
                begin
                    src_idle_pct = 26;
                    snk_idle_pct = 77;
                end
                else if (random_item_count < 2 * RANDOM_ITEMS / 3)
                begin
                    src_idle_pct = 77;
                    snk_idle_pct = 26;
                end
                else
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                queue_scalar($urandom_range(99) < 25, ($urandom_range(9) == 0) ? 24 : 8);
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("[quoted_utf8_text_validator] OK");
        else
            $display("[quoted_utf8_text_validator] ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/qutv_pkg.sv
sv/qutv_in_if.sv
sv/qutv_out_if.sv
sv/quoted_utf8_text_validator.sv
verif/testbench.sv
